// File: rtl/core/error_diffusion_binarizer_top_assert.svh
// Assertion macros used by the top level of the binarizer RTL.
`ifndef ERROR_DIFFUSION_BINARIZER_TOP_ASSERT_SVH
`define ERROR_DIFFUSION_BINARIZER_TOP_ASSERT_SVH

// Check that expr holds in the same cycle as cond.
`define EDB_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that expr holds in the cycle after cond.
`define EDB_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: rtl/core/edb_pkg.sv
// Shared types, constants and helpers of the error diffusion binarizer.
package edb_pkg;

	// Line store geometry
	localparam int MaxWidth = 4096;
	localparam int ColW = $clog2(MaxWidth);

	// Register widths and reset values
	localparam int WidthRegW = 13;
	localparam int ThrW = 8;
	localparam logic [WidthRegW-1:0] WidthReset = WidthRegW'(4096);
	localparam logic [ThrW-1:0] ThrReset = ThrW'(127);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH = 1'b0,
		REG_THRESHOLD   = 1'b1
	} cfg_reg_t;

	// floor(n / 1000) as (n * DivRecip) >> DivShift, exact for n below 2^18
	localparam int DivShift = 27;
	localparam longint DivRecip = 134218;
	localparam int LumaMulW = 27;
	localparam logic [LumaMulW-1:0] MulRed = LumaMulW'(299 * DivRecip);
	localparam logic [LumaMulW-1:0] MulGreen = LumaMulW'(587 * DivRecip);
	localparam logic [LumaMulW-1:0] MulBlue = LumaMulW'(114 * DivRecip);
	localparam int LumaProdW = 8 + LumaMulW;

	// Queue between front and back
	localparam int FifoDepth = 4;
	localparam int FifoPtrW = $clog2(FifoDepth);

	// One classified pixel
	typedef struct packed {
		logic [7:0]      gray;
		logic [ColW-1:0] col;
		logic            last;
		logic            first_row;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_st_t;

	// Pending errors left for the next row at one column
	typedef struct packed {
		logic signed [6:0] diag;
		logic signed [7:0] above;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	function automatic logic [7:0] clamp_byte(input logic signed [9:0] v);
		logic [7:0] r;
		if (v < 10'sd0) begin
			r = 8'd0;
		end else if (v > 10'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/edb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module edb_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/edb_fifo.sv
// Short queue of classified pixels between front and back.
module edb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  edb_pkg::item_t     push_item,
	input  logic               pop,
	output edb_pkg::item_t     head,
	output edb_pkg::fifo_st_t  st
);

	edb_pkg::item_t                  buf_q [edb_pkg::FifoDepth];
	logic [edb_pkg::FifoPtrW-1:0]    wr_ptr_q;
	logic [edb_pkg::FifoPtrW-1:0]    rd_ptr_q;
	logic [edb_pkg::FifoPtrW:0]      count_q;

	assign head = buf_q[rd_ptr_q];
	assign st.empty = (count_q == '0);
	assign st.full = (count_q == (edb_pkg::FifoPtrW+1)'(edb_pkg::FifoDepth));

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/edb_front.sv
// Front part: accept pixels, form gray, track column and row position.
module edb_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,
	input  logic                                s_tuser,
	input  logic [edb_pkg::WidthRegW-1:0]       image_width,
	input  edb_pkg::fifo_st_t                   fifo_st,
	output logic                                push,
	output edb_pkg::item_t                      item
);

	logic [edb_pkg::ColW-1:0]      col_q;
	logic                          first_row_q;
	logic [edb_pkg::ColW-1:0]      col;
	logic [edb_pkg::ColW-1:0]      last_col;
	logic                          first_row;
	logic                          last;
	logic [edb_pkg::LumaProdW-1:0] prod_r;
	logic [edb_pkg::LumaProdW-1:0] prod_g;
	logic [edb_pkg::LumaProdW-1:0] prod_b;
	logic [8:0]                    gray_sum;

	assign s_tready = !fifo_st.full;
	assign push = s_tvalid && s_tready;

	// Clip the width register into 1..MaxWidth
	always_comb begin
		if (image_width == '0) begin
			last_col = '0;
		end else if (32'(image_width) > edb_pkg::MaxWidth) begin
			last_col = edb_pkg::ColW'(edb_pkg::MaxWidth - 1);
		end else begin
			last_col = edb_pkg::ColW'(image_width - 1'b1);
		end
	end

	assign col = s_tuser ? '0 : col_q;
	assign first_row = s_tuser ? 1'b1 : first_row_q;
	assign last = (col >= last_col);

	assign prod_r = edb_pkg::LumaProdW'(s_tdata[7:0]) * edb_pkg::LumaProdW'(edb_pkg::MulRed);
	assign prod_g = edb_pkg::LumaProdW'(s_tdata[15:8]) * edb_pkg::LumaProdW'(edb_pkg::MulGreen);
	assign prod_b = edb_pkg::LumaProdW'(s_tdata[23:16]) * edb_pkg::LumaProdW'(edb_pkg::MulBlue);
	assign gray_sum = 9'(prod_r[edb_pkg::DivShift +: 8]) + 9'(prod_g[edb_pkg::DivShift +: 8])
		+ 9'(prod_b[edb_pkg::DivShift +: 8]);

	always_comb begin
		item.gray = gray_sum[7:0];
		item.col = col;
		item.last = last;
		item.first_row = first_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_row_q <= 1'b1;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col + 1'b1;
				first_row_q <= first_row;
			end
		end
	end

endmodule

// File: rtl/core/edb_back.sv
// Back part: apply pending errors, decide black or white, spread the error.
module edb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  edb_pkg::item_t            head,
	input  edb_pkg::fifo_st_t         fifo_st,
	output logic                      pop,
	input  logic [edb_pkg::ThrW-1:0]  threshold,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,
	output logic                      m_tlast,
	output logic                      busy
);

	edb_pkg::item_t            item_s2;
	logic                      vld_s2;
	logic                      byp_hit_s2;
	edb_pkg::entry_t           byp_data_s2;
	logic [edb_pkg::EntryW-1:0] rdata;
	logic signed [7:0]         carry_right_q;
	logic signed [6:0]         carry_diag_q;
	logic                      m_tvalid_q;
	logic                      white_q;
	logic                      last_q;

	logic                      out_free;
	logic                      adv;
	logic                      col0;
	edb_pkg::entry_t           ent;
	edb_pkg::entry_t           wr_ent;
	logic signed [9:0]         gray_s;
	logic [7:0]                v1;
	logic [7:0]                v2;
	logic [7:0]                v3;
	logic signed [7:0]         cr;
	logic                      white;
	logic signed [9:0]         err;
	logic signed [11:0]        err12;
	logic signed [11:0]        err3;
	logic signed [11:0]        rb_full;
	logic signed [9:0]         dg_full;

	assign out_free = !m_tvalid_q || m_tready;
	assign adv = vld_s2 && out_free;
	assign pop = !fifo_st.empty && (!vld_s2 || out_free);
	assign busy = vld_s2;

	edb_ram #(
		.Width(edb_pkg::EntryW),
		.Depth(edb_pkg::MaxWidth)
	) u_line (
		.clk  (clk),
		.we   (adv),
		.waddr(item_s2.col),
		.wdata(wr_ent),
		.re   (pop),
		.raddr(head.col),
		.rdata(rdata)
	);

	// Forward the entry written in the cycle it is read back
	assign ent = byp_hit_s2 ? byp_data_s2 : edb_pkg::entry_t'(rdata);
	assign col0 = (item_s2.col == '0);
	assign cr = col0 ? 8'sd0 : carry_right_q;
	assign gray_s = $signed({2'b00, item_s2.gray});

	always_comb begin
		if (item_s2.first_row) begin
			v1 = item_s2.gray;
			v2 = item_s2.gray;
		end else begin
			v1 = edb_pkg::clamp_byte(gray_s + 10'(ent.diag));
			v2 = edb_pkg::clamp_byte($signed({2'b00, v1}) + 10'(ent.above));
		end
		v3 = edb_pkg::clamp_byte($signed({2'b00, v2}) + 10'(cr));
		white = (v3 > threshold);
		err = white ? ($signed({2'b00, v3}) - 10'sd255) : $signed({2'b00, v3});
		err12 = {{2{err[9]}}, err};
		err3 = (err12 <<< 1) + err12;
		// Truncate toward zero
		rb_full = (err3 + (err3[11] ? 12'sd7 : 12'sd0)) >>> 3;
		dg_full = (err + (err[9] ? 10'sd3 : 10'sd0)) >>> 2;
		wr_ent.diag = col0 ? 7'sd0 : carry_diag_q;
		wr_ent.above = rb_full[7:0];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s2 <= head;
			byp_data_s2 <= wr_ent;
		end
		if (adv) begin
			carry_right_q <= rb_full[7:0];
			carry_diag_q <= dg_full[6:0];
			white_q <= white;
			last_q <= item_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			byp_hit_s2 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s2 <= 1'b1;
				byp_hit_s2 <= adv && (item_s2.col == head.col);
			end else if (adv) begin
				vld_s2 <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {7'b0, white_q};
	assign m_tlast = last_q;

endmodule

// File: rtl/core/error_diffusion_binarizer_top.sv
// Top level of the error diffusion binarizer.
// Turns a raster stream of RGB pixels into one black or white bit per pixel
// by simplified Floyd-Steinberg error diffusion. The block takes one pixel
// per clock and gives one result per clock when neither side stalls; a pixel's
// result word passes through the queue entry, the line store read and the
// output register before it is valid. The sustained rate is set by the back
// stage, which reads and writes the line store once per pixel and closes the
// loop through the registered right and diagonal error carries. The line
// store holds one entry per column (up to 4096) and is not cleared after
// reset: the first row of each frame ignores it, so no clearing pass runs.
// Write image_width and threshold only while the block is idle; a width of 0
// acts as 1 and anything above 4096 acts as 4096. A start-of-frame flag on
// s_tuser drops all pending errors and starts a new first row.
module error_diffusion_binarizer_top (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic        s_tuser,   // start_of_frame
	// Binary output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // is_white [0], zero [7:1]
	output logic        m_tlast,   // end_of_row
	// Register writes
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);

	`include "error_diffusion_binarizer_top_assert.svh"

	logic [edb_pkg::WidthRegW-1:0] image_width_q;
	logic [edb_pkg::ThrW-1:0]      threshold_q;
	edb_pkg::item_t                push_item;
	edb_pkg::item_t                head;
	edb_pkg::fifo_st_t             fifo_st;
	logic                          push;
	logic                          pop;
	logic                          back_busy;

	// Hold register values; take a write whenever enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= edb_pkg::WidthReset;
			threshold_q <= edb_pkg::ThrReset;
		end else if (cfg_we) begin
			unique case (edb_pkg::cfg_reg_t'(cfg_index))
				edb_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_wdata;
				edb_pkg::REG_THRESHOLD:   threshold_q <= cfg_wdata[edb_pkg::ThrW-1:0];
				default: ;
			endcase
		end
	end

	// Front: accept the word, form gray and position
	edb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.image_width(image_width_q),
		.fifo_st    (fifo_st),
		.push       (push),
		.item       (push_item)
	);

	// Queue: decouple input stalls from output stalls
	edb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.st       (fifo_st)
	);

	// Back: apply errors, threshold, update line store and carries
	edb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.fifo_st  (fifo_st),
		.pop      (pop),
		.threshold(threshold_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.busy     (back_busy)
	);

	`EDB_ASSERT_NEXT(a_push_fills_queue, push, !fifo_st.empty, "queue empty after a push")
	`EDB_ASSERT_NOW(a_queue_status, 1'b1, !(fifo_st.empty && fifo_st.full), "queue full and empty")
	`EDB_ASSERT_NOW(a_result_from_back, $rose(m_tvalid), $past(back_busy), "result without work")
	`EDB_ASSERT_NOW(a_pop_nonempty, pop, !fifo_st.empty, "pop from empty queue")

endmodule

// File: tb/error_diffusion_binarizer_top_tb.sv
// Self-checking testbench of the error diffusion binarizer: directed and random pixel streams.
module error_diffusion_binarizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected output word of one pixel
	typedef struct {
		bit is_white;
		bit end_of_row;
	} pixel_bits_t;

	// Predict the black/white bit of every accepted pixel and compare output words in order.
	class binarizer_scoreboard;
		int line_diag[edb_pkg::MaxWidth];
		int line_above[edb_pkg::MaxWidth];
		int column;
		int carry_right;
		int carry_diag;
		bit first_row;
		int width_reg;
		int thr_reg;
		pixel_bits_t expected_q[$];
		int mismatches;

		function new();
			column = 0;
			carry_right = 0;
			carry_diag = 0;
			first_row = 1'b1;
			width_reg = int'(edb_pkg::WidthReset);
			thr_reg = int'(edb_pkg::ThrReset);
			mismatches = 0;
		endfunction

		function void set_register(edb_pkg::cfg_reg_t idx, int value);
			case (idx)
				edb_pkg::REG_IMAGE_WIDTH: begin
					width_reg = value & 'h1FFF;
				end
				edb_pkg::REG_THRESHOLD: begin
					thr_reg = value & 'hFF;
				end
			endcase
		endfunction

		function int sat_byte(int v);
			if (v < 0) begin
				return 0;
			end
			if (v > 255) begin
				return 255;
			end
			return v;
		endfunction

		function void record_pixel(logic [23:0] data, logic sof);
			int r, g, b, w, x, v, err, right_below, diag;
			pixel_bits_t want;
			r = int'(data[7:0]);
			g = int'(data[15:8]);
			b = int'(data[23:16]);
			w = width_reg;
			if (w < 1) begin
				w = 1;
			end
			if (w > edb_pkg::MaxWidth) begin
				w = edb_pkg::MaxWidth;
			end
			// start of frame drops everything pending
			if (sof) begin
				column = 0;
				first_row = 1'b1;
				carry_right = 0;
				carry_diag = 0;
			end
			x = column;
			if (x >= edb_pkg::MaxWidth) begin
				x = edb_pkg::MaxWidth - 1;
			end
			want.end_of_row = (x >= w - 1);
			v = r * 299 / 1000 + g * 587 / 1000 + b * 114 / 1000;
			// take upper-left, then above, then left, clamping after each
			if (!first_row) begin
				v = sat_byte(v + line_diag[x]);
				v = sat_byte(v + line_above[x]);
			end
			v = sat_byte(v + carry_right);
			want.is_white = (v > thr_reg);
			err = want.is_white ? v - 255 : v;
			right_below = err * 3 / 8;
			diag = err * 2 / 8;
			line_diag[x] = carry_diag;
			line_above[x] = right_below;
			if (want.end_of_row) begin
				column = 0;
				first_row = 1'b0;
				carry_right = 0;
				carry_diag = 0;
			end else begin
				column = x + 1;
				carry_right = right_below;
				carry_diag = diag;
			end
			expected_q.push_back(want);
		endfunction

		function void check_word(logic [7:0] data, logic last);
			pixel_bits_t want;
			if (expected_q.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected output word: data=%h last=%b", data, last);
				end
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (data[0] !== want.is_white || last !== want.end_of_row || data[7:1] !== 7'd0) begin
				if (mismatches < 10) begin
					$display("mismatch: expected is_white=%0d end_of_row=%0d, got data=%h last=%b",
						want.is_white, want.end_of_row, data, last);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
	logic        s_tuser = 1'b0; // start_of_frame
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // is_white [0], zero [7:1]
	logic        m_tlast;        // end_of_row
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [12:0] cfg_wdata = '0;

	binarizer_scoreboard sb;
	int src_gap_max = 10;
	int snk_gap_max = 10;
	int hold_cycles = 0;
	int sent = 0;

	error_diffusion_binarizer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample both handshakes at the edge: note the pixel first, then check the word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.record_pixel(s_tdata, s_tuser);
			end
			if (m_tvalid && m_tready) begin
				sb.check_word(m_tdata, m_tlast);
			end
		end
	end

	// Output side: draw a stall before every word; take a long hold when one is requested.
	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				gap = hold_cycles;
				hold_cycles = 0;
			end else begin
				gap = $urandom_range(0, snk_gap_max);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offer one pixel after a random gap and hold it until the block takes the word.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic sof);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Stop offering and wait until every predicted word has come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; call only while the block is idle.
	task automatic write_reg(input edb_pkg::cfg_reg_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[12:0];
		@(posedge clk);
		sb.set_register(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_pacing();
		if ($urandom_range(0, 3) == 0) begin
			src_gap_max = 0;
			snk_gap_max = 0;
		end else begin
			src_gap_max = 10;
			snk_gap_max = 10;
		end
	endtask

	// Send one frame of random pixels. Start it with start of frame so the width may grow;
	// now and then shrink the width mid-frame and drop in a stray start of frame.
	task automatic run_frame(input int width, input int thr, input int count);
		int cut;
		drain_results();
		write_reg(edb_pkg::REG_IMAGE_WIDTH, width);
		write_reg(edb_pkg::REG_THRESHOLD, thr);
		cut = -1;
		if (width > 1 && count > 1 && $urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, count - 1);
		end
		for (int i = 0; i < count; i++) begin
			if (i == cut) begin
				drain_results();
				write_reg(edb_pkg::REG_IMAGE_WIDTH, $urandom_range(1, width));
			end
			send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 49) == 0);
		end
	endtask

	initial begin
		int w, thr, rows, sel;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rows right after reset, without start of frame: the first row ignores the line store.
		write_reg(edb_pkg::REG_IMAGE_WIDTH, 4);
		write_reg(edb_pkg::REG_THRESHOLD, 127);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd90, 8'd90, 8'd90, 1'b0);
		// start of frame in the middle of a row
		send_pixel(8'd64, 8'd200, 8'd30, 1'b1);
		drain_results();

		// Width 0 acts as 1; threshold 0 makes any nonzero gray white.
		write_reg(edb_pkg::REG_IMAGE_WIDTH, 0);
		write_reg(edb_pkg::REG_THRESHOLD, 0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
		send_pixel(8'd4, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		drain_results();

		// Threshold 255: every pixel is black.
		write_reg(edb_pkg::REG_IMAGE_WIDTH, 3);
		write_reg(edb_pkg::REG_THRESHOLD, 255);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		drain_results();

		// Shrink the width mid-row: the next pixel is past the new last column and ends the row.
		write_reg(edb_pkg::REG_IMAGE_WIDTH, 8);
		write_reg(edb_pkg::REG_THRESHOLD, 100);
		send_pixel(8'd200, 8'd150, 8'd100, 1'b1);
		send_pixel(8'd50, 8'd60, 8'd70, 1'b0);
		send_pixel(8'd180, 8'd20, 8'd240, 1'b0);
		send_pixel(8'd10, 8'd250, 8'd5, 1'b0);
		send_pixel(8'd120, 8'd120, 8'd120, 1'b0);
		drain_results();
		write_reg(edb_pkg::REG_IMAGE_WIDTH, 2);
		send_pixel(8'd33, 8'd66, 8'd99, 1'b0);
		send_pixel(8'd140, 8'd130, 8'd150, 1'b0);
		send_pixel(8'd70, 8'd90, 8'd110, 1'b0);

		// Hold the output off for a long stretch while the input keeps offering,
		// so the queue fills and the block stalls its input.
		drain_results();
		src_gap_max = 0;
		snk_gap_max = 10;
		hold_cycles = 300;
		run_frame(12, 127, 60);

		// Random frames: mostly narrow, a few wider, rows of random content.
		while (sent < 850) begin
			sel = $urandom_range(0, 19);
			if (sel < 14) begin
				w = $urandom_range(1, 16);
				rows = $urandom_range(1, 6);
			end else if (sel < 19) begin
				w = $urandom_range(17, 64);
				rows = $urandom_range(1, 4);
			end else begin
				w = $urandom_range(65, 300);
				rows = 2;
			end
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				thr = 0;
			end else if (sel == 1) begin
				thr = 255;
			end else begin
				thr = $urandom_range(0, 255);
			end
			pick_pacing();
			// sometimes leave a partial bottom row
			run_frame(w, thr, w * rows + (($urandom_range(0, 3) == 0) ? $urandom_range(1, w) : 0));
		end

		// Full width, then a width above range that acts as full width, without idling;
		// both stay within a partial first row.
		src_gap_max = 10;
		snk_gap_max = 10;
		run_frame(edb_pkg::MaxWidth, 127, 200);
		src_gap_max = 0;
		snk_gap_max = 0;
		run_frame(8191, 127, 200);

		drain_results();
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/edb_pkg.sv
rtl/core/edb_ram.sv
rtl/core/edb_fifo.sv
rtl/core/edb_front.sv
rtl/core/edb_back.sv
rtl/core/error_diffusion_binarizer_top.sv
tb/error_diffusion_binarizer_top_tb.sv
